// File: hdl/static_word_substitution_encoder_unit_defines.svh
// Assertion macros for the word substitution encoder.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef STATIC_WORD_SUBSTITUTION_ENCODER_UNIT_DEFINES_SVH
`define STATIC_WORD_SUBSTITUTION_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SWSE_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("swse: implication check failed");
`define SWSE_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("swse: next-cycle check failed");
`else
`define SWSE_ASSERT_IMP(label, pre, post)
`define SWSE_ASSERT_NXT(label, pre, post)
`endif
`endif

// File: hdl/swse_pkg.sv
// Shared types and dictionary constants for the word substitution encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swse_pkg;

  localparam int WIN_BYTES = 4;
  localparam int CNT_W     = 3;
  localparam int DICT_SIZE = 14;

  // Dictionary text, first byte in the top byte lane, unused lanes zero.
  localparam logic [31:0] DICT_TEXT [DICT_SIZE] = '{
    32'h54686500, 32'h74686500, 32'h416E6400, 32'h616E6400,
    32'h74686174, 32'h68617665, 32'h666F7200, 32'h6E6F7400,
    32'h77697468, 32'h796F7500, 32'h596F7500, 32'h74686973,
    32'h22000000, 32'h0A000000
  };
  localparam logic [CNT_W-1:0] DICT_LEN [DICT_SIZE] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd1, 3'd1
  };
  localparam logic [7:0] CODE_LEAD [DICT_SIZE] = '{
    8'hC2, 8'hC2, 8'hC2, 8'hC2, 8'hC2, 8'hC2, 8'hC2, 8'hC2,
    8'hC2, 8'hC2, 8'hC2, 8'hC2, 8'h24, 8'h5E
  };
  localparam logic [7:0] CODE_TRAIL [DICT_SIZE] = '{
    8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8,
    8'hA9, 8'hAA, 8'hB0, 8'hB1, 8'h00, 8'h00
  };
  localparam logic DICT_TWO [DICT_SIZE] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0
  };

  // One head decision: code bytes and how many window bytes it consumes.
  typedef struct packed {
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic             two_bytes;
    logic [CNT_W-1:0] drop;
  } decision_t;

  // Push into the output queue.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two_bytes;
    logic       fin;
  } push_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } q_entry_t;

endpackage
`default_nettype wire

// File: hdl/swse_match.sv
// Head-of-window dictionary matcher with fixed priority.
// Depends on swse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swse_match (
  input  logic [31:0]                win,
  input  logic [swse_pkg::CNT_W-1:0] win_cnt,
  output swse_pkg::decision_t        dec
);
  import swse_pkg::*;

  logic [DICT_SIZE-1:0] hit;

  always_comb begin
    for (int e = 0; e < DICT_SIZE; e++) begin
      hit[e] = (DICT_LEN[e] <= win_cnt);
      for (int i = 0; i < WIN_BYTES; i++) begin
        if ((CNT_W'(i) < DICT_LEN[e]) &&
            (win[31-8*i -: 8] != DICT_TEXT[e][31-8*i -: 8])) begin
          hit[e] = 1'b0;
        end
      end
    end
  end

  // lowest index wins; no hit passes the head byte through
  always_comb begin
    dec.byte0     = win[31:24];
    dec.byte1     = 8'h00;
    dec.two_bytes = 1'b0;
    dec.drop      = CNT_W'(1);
    for (int e = DICT_SIZE - 1; e >= 0; e--) begin
      if (hit[e]) begin
        dec.byte0     = CODE_LEAD[e];
        dec.byte1     = CODE_TRAIL[e];
        dec.two_bytes = DICT_TWO[e];
        dec.drop      = DICT_LEN[e];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/swse_outq.sv
// Two-entry output queue; 1-2 bytes per push, one beat out per cycle when ready.
// Depends on swse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swse_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_en,
  input  swse_pkg::push_t push,
  output logic [1:0]      free,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_code_byte,
  output logic            out_final_out
);
  import swse_pkg::*;

  q_entry_t   q_r   [2];
  q_entry_t   q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;
  logic       pop;
  q_entry_t   first, second;

  assign out_valid     = (cnt_r != 2'd0);
  assign out_code_byte = q_r[0].data;
  assign out_final_out = q_r[0].fin;
  assign pop           = out_valid && out_ready;
  assign free          = 2'd2 - cnt_r + {1'b0, pop};
  assign base          = cnt_r - {1'b0, pop};

  always_comb begin
    first.data  = push.byte0;
    first.fin   = push.fin && !push.two_bytes;
    second.data = push.byte1;
    second.fin  = push.fin;

    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = base;
    if (push_en) begin
      if (base == 2'd0) begin
        q_nxt[0] = first;
        q_nxt[1] = second;
      end else begin
        q_nxt[1] = first;
      end
      cnt_nxt = base + (push.two_bytes ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

endmodule
`default_nettype wire

// File: hdl/static_word_substitution_encoder_unit.sv
// Word substitution encoder top level: look-ahead window, head decision, output queue.
// Depends on swse_pkg, swse_match, swse_outq and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
// Byte-stream encoder that swaps fourteen fixed dictionary entries for short
// codes. Input bytes collect in a four-byte window; a byte that does not fill
// it is simply added to the window. A byte that fills the window, or carries
// end_of_stream, is followed by head decisions, one per cycle while the queue
// has room, with in_ready low: one decision for a full window, up to four
// while flushing at end of stream. Each decision pushes one or two bytes into
// a two-entry output queue and waits if the queue lacks room. A byte that fills
// the window waits for its decision before the next byte is taken; unmatched
// text passes one byte per decision, a matched entry one, three or four bytes.
// The output port moves one byte per cycle while out_ready is high; the first
// output beat is registered through the window count and then the output queue.
`include "static_word_substitution_encoder_unit_defines.svh"
module static_word_substitution_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_final_out
);
  import swse_pkg::*;

  logic [31:0]      win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             flush_r, flush_nxt;
  logic             pend, accept, decide;
  logic [1:0]       q_free, need;
  decision_t        dec;
  push_t            push;

  swse_match u_match (
    .win     (win_r),
    .win_cnt (cnt_r),
    .dec     (dec)
  );

  // a head decision is owed while the window is full or a flush runs
  assign pend     = (cnt_r == CNT_W'(WIN_BYTES)) || flush_r;
  assign in_ready = !pend;
  assign accept   = in_valid && in_ready;
  assign need     = dec.two_bytes ? 2'd2 : 2'd1;
  assign decide   = pend && (q_free >= need);

  assign push.byte0     = dec.byte0;
  assign push.byte1     = dec.byte1;
  assign push.two_bytes = dec.two_bytes;
  assign push.fin       = flush_r && (dec.drop == cnt_r);

  swse_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .push_en       (decide),
    .push          (push),
    .free          (q_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_byte (out_code_byte),
    .out_final_out (out_final_out)
  );

  always_comb begin
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    flush_nxt = flush_r;
    if (accept) begin
      // lanes past the count are always zero, so OR in the new byte
      win_nxt   = win_r | ({in_data_byte, 24'h000000} >> {cnt_r, 3'b000});
      cnt_nxt   = cnt_r + CNT_W'(1);
      flush_nxt = in_end_of_stream;
    end else if (decide) begin
      win_nxt = win_r << {dec.drop, 3'b000};
      cnt_nxt = cnt_r - dec.drop;
      if (dec.drop == cnt_r) begin
        flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      cnt_r   <= '0;
      flush_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
    end
  end

  `SWSE_ASSERT_IMP(a_drop_in_window, decide, dec.drop <= cnt_r)
  `SWSE_ASSERT_IMP(a_push_fits, decide && dec.two_bytes, q_free == 2'd2)
  `SWSE_ASSERT_NXT(a_eos_flushes, accept && in_end_of_stream, flush_r && !in_ready)

endmodule
`default_nettype wire
